/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL file lpht_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define LPHT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define LPHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/lpht_pkg.sv */
`timescale 1ns / 1ps
package lpht_pkg;

    localparam int DEPTH      = 1024;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int SIZE_W     = IDX_W + 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int FULL_W     = CNT_W + 5;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;
    localparam int MOD_RADIX  = 4;
    localparam int MOD_STEPS  = KEY_W / MOD_RADIX;
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);
    localparam int ADDR_W     = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_ZERO_KEY  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_F_RD,
        B_F_CHK,
        B_R_RD,
        B_R_CHK,
        B_R_MOD,
        B_P_RD,
        B_P_CHK
    } t_back_state;

    // One queued operation with its precomputed home slot.
    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] home;
    } t_item;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_W'(1);
        end else if (s > SIZE_W'(DEPTH)) begin
            r = SIZE_W'(DEPTH);
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i,
                                                   input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] t;
        t = {1'b0, i} + SIZE_W'(1);
        return (t >= s) ? '0 : t[IDX_W-1:0];
    endfunction

endpackage

/* rtl/core/lpht_ram.sv */
`timescale 1ns / 1ps
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lpht_mod.sv */
`timescale 1ns / 1ps
module lpht_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lpht_pkg::KEY_W-1:0]   i_dividend,
    input  logic [lpht_pkg::SIZE_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [lpht_pkg::IDX_W-1:0]   o_rem
);

    // Restoring remainder, several dividend bits per cycle.
    logic                            r_busy;
    logic                            r_done;
    logic [lpht_pkg::MOD_CNT_W-1:0]  r_cnt;
    logic [lpht_pkg::SIZE_W-1:0]     r_rem;
    logic [lpht_pkg::KEY_W-1:0]      r_dvd;
    logic [lpht_pkg::SIZE_W-1:0]     n_rem;
    logic [lpht_pkg::KEY_W-1:0]      n_dvd;

    always_comb begin
        logic [lpht_pkg::SIZE_W:0] t;
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int j = 0; j < lpht_pkg::MOD_RADIX; j++) begin
            t = {n_rem, n_dvd[lpht_pkg::KEY_W-1]};
            n_dvd = n_dvd << 1;
            if (t >= {1'b0, i_divisor}) begin
                t = t - {1'b0, i_divisor};
            end
            n_rem = t[lpht_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[lpht_pkg::IDX_W-1:0];

endmodule

/* rtl/core/lpht_front.sv */
`timescale 1ns / 1ps
module lpht_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  lpht_pkg::t_op                i_op,
    input  logic [lpht_pkg::KEY_W-1:0]   i_key,
    input  logic [lpht_pkg::VAL_W-1:0]   i_value,
    input  logic [lpht_pkg::SIZE_W-1:0]  i_size,
    input  logic                         i_pop,
    output logic                         o_busy,
    output logic                         o_q_valid,
    output lpht_pkg::t_item              o_q_item
);

    logic                            r_pend;
    logic                            r_got;
    lpht_pkg::t_item                 r_item;
    lpht_pkg::t_item                 r_q [lpht_pkg::Q_DEPTH];
    logic [lpht_pkg::Q_PTR_W-1:0]    r_wp;
    logic [lpht_pkg::Q_PTR_W-1:0]    r_rp;
    logic [lpht_pkg::Q_CNT_W-1:0]    r_qcnt;
    logic                            mod_done;
    logic [lpht_pkg::IDX_W-1:0]      mod_rem;
    logic                            push;

    lpht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_accept),
        .i_dividend (i_key),
        .i_divisor  (i_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign push = r_got && (r_qcnt != lpht_pkg::Q_CNT_W'(lpht_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_got  <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            if (i_accept) begin
                r_pend <= 1'b1;
            end else if (push) begin
                r_pend <= 1'b0;
            end
            if (mod_done) begin
                r_got <= 1'b1;
            end else if (push) begin
                r_got <= 1'b0;
            end
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_qcnt <= r_qcnt + lpht_pkg::Q_CNT_W'(push) - lpht_pkg::Q_CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item.op    <= i_op;
            r_item.key   <= i_key;
            r_item.value <= i_value;
        end
        if (mod_done) begin
            r_item.home <= mod_rem;
        end
        if (push) begin
            r_q[r_wp] <= r_item;
        end
    end

    assign o_busy    = r_pend;
    assign o_q_valid = (r_qcnt != '0);
    assign o_q_item  = r_q[r_rp];

endmodule

/* rtl/core/lpht_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lpht_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lpht_pkg::SIZE_W-1:0]  i_size,
    input  logic                         i_q_valid,
    input  lpht_pkg::t_item              i_q_item,
    output logic                         o_pop,
    output logic                         o_clearing,
    output logic                         o_done,
    output lpht_pkg::t_status            o_status,
    output logic [lpht_pkg::VAL_W-1:0]   o_found_value,
    output logic [lpht_pkg::CNT_W-1:0]   o_entry_total
);

    lpht_pkg::t_back_state           r_state, n_state;
    logic [lpht_pkg::IDX_W-1:0]      r_clr;
    lpht_pkg::t_op                   r_op;
    logic [lpht_pkg::KEY_W-1:0]      r_key, n_key;
    logic [lpht_pkg::VAL_W-1:0]      r_val, n_val;
    logic [lpht_pkg::IDX_W-1:0]      r_addr, n_addr;
    logic [lpht_pkg::SIZE_W-1:0]     r_n, n_n;
    logic [lpht_pkg::IDX_W-1:0]      r_scan, n_scan;
    logic [lpht_pkg::SIZE_W-1:0]     r_sn, n_sn;
    logic [lpht_pkg::KEY_W-1:0]      r_mk, n_mk;
    logic [lpht_pkg::VAL_W-1:0]      r_mv, n_mv;
    logic [lpht_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_done, n_fin;
    lpht_pkg::t_status               r_status, n_status;
    logic [lpht_pkg::VAL_W-1:0]      r_found, n_found;
    logic [lpht_pkg::CNT_W-1:0]      r_total;

    logic                            key_we, val_we;
    logic [lpht_pkg::IDX_W-1:0]      waddr, raddr;
    logic [lpht_pkg::KEY_W-1:0]      key_wdata;
    logic [lpht_pkg::VAL_W-1:0]      val_wdata;
    logic [lpht_pkg::KEY_W-1:0]      key_rdata;
    logic [lpht_pkg::VAL_W-1:0]      val_rdata;
    logic                            mod_start, mod_done;
    logic [lpht_pkg::IDX_W-1:0]      mod_rem;
    logic [lpht_pkg::FULL_W-1:0]     load_lhs, load_rhs;
    logic [lpht_pkg::CNT_W:0]        cnt_inc;
    logic                            probe_last, scan_last;

    lpht_ram #(.WIDTH(lpht_pkg::KEY_W), .DEPTH(lpht_pkg::DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    lpht_ram #(.WIDTH(lpht_pkg::VAL_W), .DEPTH(lpht_pkg::DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (val_rdata)
    );

    lpht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_mk),
        .i_divisor  (i_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Load limit: 10 * (count + 1) >= 9 * size.
    assign cnt_inc  = {1'b0, r_count} + 1'b1;
    assign load_lhs = (lpht_pkg::FULL_W'(cnt_inc) << 3) + (lpht_pkg::FULL_W'(cnt_inc) << 1);
    assign load_rhs = (lpht_pkg::FULL_W'(i_size) << 3) + lpht_pkg::FULL_W'(i_size);

    assign probe_last = ({1'b0, r_n} + 1'b1) >= {1'b0, i_size};
    assign scan_last  = ({1'b0, r_sn} + 1'b1) >= {1'b0, i_size};

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_val     = r_val;
        n_addr    = r_addr;
        n_n       = r_n;
        n_scan    = r_scan;
        n_sn      = r_sn;
        n_mk      = r_mk;
        n_mv      = r_mv;
        n_count   = r_count;
        n_fin     = 1'b0;
        n_status  = r_status;
        n_found   = r_found;
        key_we    = 1'b0;
        val_we    = 1'b0;
        waddr     = r_addr;
        key_wdata = '0;
        val_wdata = r_val;
        raddr     = r_addr;
        mod_start = 1'b0;
        o_pop     = 1'b0;

        case (r_state)
            lpht_pkg::B_CLEAR: begin
                key_we = 1'b1;
                waddr  = r_clr;
                if (r_clr == lpht_pkg::IDX_W'(lpht_pkg::DEPTH - 1)) begin
                    n_state = lpht_pkg::B_IDLE;
                end
            end
            lpht_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_key   = i_q_item.key;
                    n_val   = i_q_item.value;
                    n_addr  = i_q_item.home;
                    n_n     = '0;
                    n_found = '0;
                    if (i_q_item.key == '0) begin
                        n_status = lpht_pkg::STS_ZERO_KEY;
                        n_fin    = 1'b1;
                    end else begin
                        case (i_q_item.op)
                            lpht_pkg::OP_INSERT: begin
                                if (load_lhs >= load_rhs) begin
                                    n_status = lpht_pkg::STS_FULL;
                                    n_fin    = 1'b1;
                                end else begin
                                    n_state = lpht_pkg::B_F_RD;
                                end
                            end
                            lpht_pkg::OP_LOOKUP, lpht_pkg::OP_DELETE: begin
                                n_state = lpht_pkg::B_F_RD;
                            end
                            default: begin
                                n_status = lpht_pkg::STS_NOT_FOUND;
                                n_fin    = 1'b1;
                            end
                        endcase
                    end
                end
            end
            lpht_pkg::B_F_RD: begin
                n_state = lpht_pkg::B_F_CHK;
            end
            lpht_pkg::B_F_CHK: begin
                n_state = lpht_pkg::B_IDLE;
                if (r_op == lpht_pkg::OP_INSERT) begin
                    if (key_rdata == '0) begin
                        key_we    = 1'b1;
                        val_we    = 1'b1;
                        key_wdata = r_key;
                        n_count   = r_count + 1'b1;
                        n_status  = lpht_pkg::STS_OK;
                        n_fin     = 1'b1;
                    end else if (probe_last) begin
                        n_status = lpht_pkg::STS_FULL;
                        n_fin    = 1'b1;
                    end else begin
                        n_addr  = lpht_pkg::next_slot(r_addr, i_size);
                        n_n     = r_n + 1'b1;
                        n_state = lpht_pkg::B_F_RD;
                    end
                end else if (key_rdata == '0) begin
                    n_status = lpht_pkg::STS_NOT_FOUND;
                    n_fin    = 1'b1;
                end else if (key_rdata == r_key) begin
                    n_status = lpht_pkg::STS_OK;
                    n_found  = val_rdata;
                    if (r_op == lpht_pkg::OP_DELETE) begin
                        // Remove the match, then re-place the rest of its run.
                        key_we  = 1'b1;
                        n_count = (r_count == '0) ? '0 : r_count - 1'b1;
                        n_scan  = lpht_pkg::next_slot(r_addr, i_size);
                        n_sn    = lpht_pkg::SIZE_W'(1);
                        if (i_size <= lpht_pkg::SIZE_W'(1)) begin
                            n_fin = 1'b1;
                        end else begin
                            n_state = lpht_pkg::B_R_RD;
                        end
                    end else begin
                        n_fin = 1'b1;
                    end
                end else if (probe_last) begin
                    n_status = lpht_pkg::STS_NOT_FOUND;
                    n_fin    = 1'b1;
                end else begin
                    n_addr  = lpht_pkg::next_slot(r_addr, i_size);
                    n_n     = r_n + 1'b1;
                    n_state = lpht_pkg::B_F_RD;
                end
            end
            lpht_pkg::B_R_RD: begin
                raddr   = r_scan;
                n_state = lpht_pkg::B_R_CHK;
            end
            lpht_pkg::B_R_CHK: begin
                if (key_rdata == '0) begin
                    n_fin   = 1'b1;
                    n_state = lpht_pkg::B_IDLE;
                end else begin
                    key_we  = 1'b1;
                    waddr   = r_scan;
                    n_count = (r_count == '0) ? '0 : r_count - 1'b1;
                    if (key_rdata == r_key) begin
                        // Same key as the deleted one: dropped.
                        if (scan_last) begin
                            n_fin   = 1'b1;
                            n_state = lpht_pkg::B_IDLE;
                        end else begin
                            n_scan  = lpht_pkg::next_slot(r_scan, i_size);
                            n_sn    = r_sn + 1'b1;
                            n_state = lpht_pkg::B_R_RD;
                        end
                    end else begin
                        n_mk    = key_rdata;
                        n_mv    = val_rdata;
                        n_state = lpht_pkg::B_R_MOD;
                    end
                end
            end
            lpht_pkg::B_R_MOD: begin
                mod_start = (r_n == '1);
                if (mod_done) begin
                    n_addr  = mod_rem;
                    n_n     = '0;
                    n_state = lpht_pkg::B_P_RD;
                end
            end
            lpht_pkg::B_P_RD: begin
                n_state = lpht_pkg::B_P_CHK;
            end
            lpht_pkg::B_P_CHK: begin
                if (key_rdata == '0 || probe_last) begin
                    if (key_rdata == '0) begin
                        key_we    = 1'b1;
                        val_we    = 1'b1;
                        key_wdata = r_mk;
                        val_wdata = r_mv;
                        n_count   = r_count + 1'b1;
                    end
                    if (scan_last) begin
                        n_fin   = 1'b1;
                        n_state = lpht_pkg::B_IDLE;
                    end else begin
                        n_scan  = lpht_pkg::next_slot(r_scan, i_size);
                        n_sn    = r_sn + 1'b1;
                        n_state = lpht_pkg::B_R_RD;
                    end
                end else begin
                    n_addr  = lpht_pkg::next_slot(r_addr, i_size);
                    n_n     = r_n + 1'b1;
                    n_state = lpht_pkg::B_P_RD;
                end
            end
            default: begin
                n_state = lpht_pkg::B_IDLE;
            end
        endcase

        // The home slot unit is kicked once on entry to the wait state.
        if (r_state == lpht_pkg::B_R_CHK && n_state == lpht_pkg::B_R_MOD) begin
            n_n = '1;
        end else if (r_state == lpht_pkg::B_R_MOD) begin
            n_n = mod_done ? '0 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::B_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lpht_pkg::B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            r_count <= n_count;
            r_done  <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_q_item.op;
        end
        r_key    <= n_key;
        r_val    <= n_val;
        r_addr   <= n_addr;
        r_n      <= n_n;
        r_scan   <= n_scan;
        r_sn     <= n_sn;
        r_mk     <= n_mk;
        r_mv     <= n_mv;
        r_status <= n_status;
        r_found  <= n_found;
        if (n_fin) begin
            r_total <= n_count;
        end
    end

    assign o_clearing    = (r_state == lpht_pkg::B_CLEAR);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_entry_total = r_total;

    `LPHT_ASSERT(a_no_result_in_clear, i_clk, i_rst_n, o_clearing |=> !r_done, "result in clear")
    `LPHT_ASSERT(a_pop_valid, i_clk, i_rst_n, o_pop |-> i_q_valid, "pop from empty queue")
    `LPHT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= lpht_pkg::CNT_W'(lpht_pkg::DEPTH), "count")

endmodule

/* rtl/core/linear_probe_hash_table_core.sv */
`timescale 1ns / 1ps
// Linear-probing key/value table with insert, lookup and delete.
// Command channel: an operation transfer happens at a rising edge where start is
// high and busy is low; operation, key and value are sampled at that edge.
// Result channel: o_done is high for exactly one cycle with o_status,
// o_found_value and o_entry_total; the receiver cannot stall, so every result
// is taken in that cycle.
// Configuration: an APB-style port holds table_size at byte address 0.
// Write it only while no operation is in flight.
// Operation: the front computes the home slot (key mod size) four bits per
// cycle and hands the item to a two-entry queue once that queue has room.
// A refused or zero-key item gives its result when it is popped from the queue;
// an insert, lookup or delete reads and then checks one slot per probe. A
// delete then reads and checks each later entry of the run, drops those with
// the deleted key and re-places the rest, probing from their own home slot.
// Flow control: busy stays high after each transfer until the item enters the
// queue; when the back is slower, the queue fills and busy stays high until
// the back pops an entry. Reset: a clearing pass writes every key slot empty,
// with busy high; configuration writes are still taken during it.
module linear_probe_hash_table_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic [lpht_pkg::KEY_W-1:0]     i_key,
    input  logic [lpht_pkg::VAL_W-1:0]     i_value,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [lpht_pkg::VAL_W-1:0]     o_found_value,
    output logic [lpht_pkg::CNT_W-1:0]     o_entry_total,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpht_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [lpht_pkg::SIZE_W-1:0]  r_table_size;
    logic [lpht_pkg::SIZE_W-1:0]  size_eff;
    logic                         front_busy;
    logic                         clearing;
    logic                         accept;
    logic                         q_valid;
    lpht_pkg::t_item              q_item;
    logic                         q_pop;
    lpht_pkg::t_status            status;

    // Register write: only word 0 holds a register; other addresses are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= lpht_pkg::SIZE_W'(lpht_pkg::DEPTH);
        end else if (psel && penable && pwrite && pready &&
                     paddr[lpht_pkg::ADDR_W-1] == 1'b0) begin
            r_table_size <= pwdata[lpht_pkg::SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[lpht_pkg::ADDR_W-1] == 1'b0) ? 32'(r_table_size) : '0;

    // A size of zero acts as one, and anything above the depth as the depth.
    assign size_eff = lpht_pkg::eff_size(r_table_size);

    // The front holds one operation at a time while its home slot is computed.
    assign busy   = front_busy || clearing;
    assign accept = start && !busy;

    lpht_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (lpht_pkg::t_op'(i_operation)),
        .i_key     (i_key),
        .i_value   (i_value),
        .i_size    (size_eff),
        .i_pop     (q_pop),
        .o_busy    (front_busy),
        .o_q_valid (q_valid),
        .o_q_item  (q_item)
    );

    lpht_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_size        (size_eff),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_pop         (q_pop),
        .o_clearing    (clearing),
        .o_done        (o_done),
        .o_status      (status),
        .o_found_value (o_found_value),
        .o_entry_total (o_entry_total)
    );

    assign o_status = status;

endmodule
